>>> design/bdm_pkg.sv
// ----------------------------------------------------------------------------
// bdm_pkg
// Shared types and constants for the Bayer demosaic to YCbCr 4:2:2 core.
// ----------------------------------------------------------------------------
package bdm_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_W     = 8;
  localparam int WORD_W    = 16;
  localparam int CFG_W     = 12;
  localparam int ROW_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd1920;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd1080;
  localparam logic [CFG_W-1:0] WIDTH_MIN  = 12'd4;
  localparam logic [CFG_W-1:0] HEIGHT_MIN = 12'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_PAD   = 1'b1
  } cmd_t;

  // 3x3 neighborhood, row-major, entry 4 is the center
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic fire;
    logic hu;
    logic hd;
    logic hl;
    logic hr;
    logic odd_row;
    logic odd_col;
    logic last;
  } pix_ctrl_t;

  typedef struct packed {
    logic [WORD_W-1:0] ycc;
    logic              pair_last;
    logic              frame_last;
  } out_word_t;

  // color conversion arithmetic
  localparam int MAG_W   = 18;
  localparam int RECIP_W = 19;
  localparam int REC_SH  = 28;
  localparam int QW      = 8;
  // floor(a / 1000) == (a * RECIP) >> REC_SH for every a below 2**18
  localparam logic [RECIP_W-1:0] RECIP = 19'd268436;

  localparam logic [MAG_W-1:0] K_Y_R  = 18'd183;
  localparam logic [MAG_W-1:0] K_Y_G  = 18'd614;
  localparam logic [MAG_W-1:0] K_Y_B  = 18'd62;
  localparam logic [MAG_W-1:0] K_CB_R = 18'd101;
  localparam logic [MAG_W-1:0] K_CB_G = 18'd338;
  localparam logic [MAG_W-1:0] K_CB_B = 18'd439;
  localparam logic [MAG_W-1:0] K_CR_R = 18'd439;
  localparam logic [MAG_W-1:0] K_CR_G = 18'd399;
  localparam logic [MAG_W-1:0] K_CR_B = 18'd40;

  localparam logic [PIX_W-1:0] Y_OFS = 8'd16;
  localparam logic [PIX_W-1:0] C_OFS = 8'd128;

  localparam int FIFO_DEPTH = 4;

endpackage

>>> design/bdm_seq.sv
// ----------------------------------------------------------------------------
// bdm_seq
// Input and output raster counters, border flags and line store read issue.
// ----------------------------------------------------------------------------
module bdm_seq import bdm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         accept,
  input  logic                         restart,
  input  logic [$clog2(MAX_WIDTH):0]   width,
  input  logic [ROW_W-1:0]             height,
  input  logic                         command,
  input  logic [WORD_W-1:0]            pixel_word,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic                         s1_valid,
  output logic [PIX_W-1:0]             s1_px,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  output pix_ctrl_t                    s1_ctrl
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic [CNT_W-1:0] col_inc, oc_inc;
  logic [ROW_W:0]   orow_inc;
  logic             col_wrap, oc_wrap;
  pix_ctrl_t        ctrl;
  logic [PIX_W-1:0] px;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [COL_W-1:0] s1_addr_r;
  pix_ctrl_t        s1_ctrl_r;

  assign col_inc  = {1'b0, in_col_r} + CNT_W'(1);
  assign col_wrap = col_inc >= width;
  assign oc_inc   = {1'b0, out_col_r} + CNT_W'(1);
  assign oc_wrap  = oc_inc >= width;
  assign orow_inc = {1'b0, out_row_r} + (ROW_W+1)'(1);

  assign px = (command == CMD_PAD) ? '0 : pixel_word[PIX_W-1:0];

  always_comb begin
    ctrl.fire    = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    ctrl.hu      = out_row_r != '0;
    ctrl.hd      = orow_inc < {1'b0, height};
    ctrl.hl      = out_col_r != '0;
    ctrl.hr      = !oc_wrap;
    ctrl.odd_row = out_row_r[0];
    ctrl.odd_col = out_col_r[0];
    ctrl.last    = ctrl.fire && out_col_r[0] && !ctrl.hd && oc_wrap;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart || (accept && ctrl.last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (accept) begin
      in_col_nxt = col_wrap ? '0 : col_inc[COL_W-1:0];
      if (col_wrap && (in_row_r < height)) begin
        in_row_nxt = in_row_r + ROW_W'(1);
      end
      if (ctrl.fire) begin
        out_col_nxt = oc_wrap ? '0 : oc_inc[COL_W-1:0];
        if (oc_wrap) begin
          out_row_nxt = orow_inc[ROW_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (adv) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= px;
      s1_addr_r <= in_col_r;
      s1_ctrl_r <= ctrl;
    end
  end

  assign rd_addr  = in_col_r;
  assign s1_valid = s1_valid_r;
  assign s1_px    = s1_px_r;
  assign s1_addr  = s1_addr_r;
  assign s1_ctrl  = s1_ctrl_r;

endmodule

>>> design/bdm_line_store.sv
// ----------------------------------------------------------------------------
// bdm_line_store
// Two-row line memory (one word per column) and the 3x3 window registers.
// ----------------------------------------------------------------------------
module bdm_line_store import bdm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         s1_valid,
  input  logic [PIX_W-1:0]             s1_px,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  input  pix_ctrl_t                    s1_ctrl,
  output logic                         s2_valid,
  output pix_ctrl_t                    s2_ctrl,
  output win_t                         win
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // upper byte: row two above, lower byte: row above
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic               wr_en;
  logic [PIX_W-1:0]   top, mid;
  win_t               win_r;
  logic               s2_valid_r;
  pix_ctrl_t          s2_ctrl_r;

  assign wr_en = s1_valid && adv;
  assign top   = rd_data_r[2*PIX_W-1:PIX_W];
  assign mid   = rd_data_r[PIX_W-1:0];

  // Column c is read as its pixel enters stage 1 and written back when that
  // stage advances; the next access to c is a full line later. The one exception
  // is column 0 right after a frame end: its read misses the pending write-back,
  // but those bytes only ever feed the masked rows above the new frame.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[s1_addr] <= {mid, s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= top;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= mid;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= s1_px;
    end
    if (adv) begin
      s2_ctrl_r <= s1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid && s1_ctrl.fire;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_ctrl  = s2_ctrl_r;
  assign win      = win_r;

endmodule

>>> design/bdm_interp.sv
// ----------------------------------------------------------------------------
// bdm_interp
// Bilinear RGGB interpolation of the window center to RGB.
// ----------------------------------------------------------------------------
module bdm_interp import bdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             s2_valid,
  input  pix_ctrl_t        s2_ctrl,
  input  win_t             win,
  output logic             s3_valid,
  output pix_ctrl_t        s3_ctrl,
  output logic [PIX_W-1:0] red,
  output logic [PIX_W-1:0] grn,
  output logic [PIX_W-1:0] blu
);

  logic [PIX_W-1:0] up, dn, lf, rt, ul, ur, dl, dr, cc;
  logic [PIX_W+1:0] cross_sum, diag_sum;
  logic [PIX_W:0]   horz_sum, vert_sum;
  logic [PIX_W-1:0] cross_avg, diag_avg, horz_avg, vert_avg;
  logic [PIX_W-1:0] red_nxt, grn_nxt, blu_nxt;
  logic [PIX_W-1:0] red_r, grn_r, blu_r;
  logic             s3_valid_r;
  pix_ctrl_t        s3_ctrl_r;

  // zero out neighbors that fall outside the frame
  always_comb begin
    cc = win[4];
    up = s2_ctrl.hu ? win[1] : '0;
    dn = s2_ctrl.hd ? win[7] : '0;
    lf = s2_ctrl.hl ? win[3] : '0;
    rt = s2_ctrl.hr ? win[5] : '0;
    ul = (s2_ctrl.hu && s2_ctrl.hl) ? win[0] : '0;
    ur = (s2_ctrl.hu && s2_ctrl.hr) ? win[2] : '0;
    dl = (s2_ctrl.hd && s2_ctrl.hl) ? win[6] : '0;
    dr = (s2_ctrl.hd && s2_ctrl.hr) ? win[8] : '0;
  end

  assign cross_sum = (PIX_W+2)'(lf) + (PIX_W+2)'(rt) + (PIX_W+2)'(up) + (PIX_W+2)'(dn);
  assign diag_sum  = (PIX_W+2)'(ul) + (PIX_W+2)'(ur) + (PIX_W+2)'(dl) + (PIX_W+2)'(dr);
  assign horz_sum  = (PIX_W+1)'(lf) + (PIX_W+1)'(rt);
  assign vert_sum  = (PIX_W+1)'(up) + (PIX_W+1)'(dn);
  assign cross_avg = cross_sum[PIX_W+1:2];
  assign diag_avg  = diag_sum[PIX_W+1:2];
  assign horz_avg  = horz_sum[PIX_W:1];
  assign vert_avg  = vert_sum[PIX_W:1];

  always_comb begin
    if (!s2_ctrl.odd_row && !s2_ctrl.odd_col) begin
      red_nxt = cc;        grn_nxt = cross_avg; blu_nxt = diag_avg;
    end else if (!s2_ctrl.odd_row) begin
      red_nxt = horz_avg;  grn_nxt = cc;        blu_nxt = vert_avg;
    end else if (s2_ctrl.odd_col) begin
      red_nxt = diag_avg;  grn_nxt = cross_avg; blu_nxt = cc;
    end else begin
      red_nxt = vert_avg;  grn_nxt = cc;        blu_nxt = horz_avg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r     <= red_nxt;
      grn_r     <= grn_nxt;
      blu_r     <= blu_nxt;
      s3_ctrl_r <= s2_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid;
    end
  end

  assign s3_valid = s3_valid_r;
  assign s3_ctrl  = s3_ctrl_r;
  assign red      = red_r;
  assign grn      = grn_r;
  assign blu      = blu_r;

endmodule

>>> design/bdm_csc.sv
// ----------------------------------------------------------------------------
// bdm_csc
// BT.709 studio-range color conversion and 4:2:2 pair packing.
// ----------------------------------------------------------------------------
module bdm_csc import bdm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             s3_valid,
  input  pix_ctrl_t        s3_ctrl,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] grn,
  input  logic [PIX_W-1:0] blu,
  output logic             push,
  output out_word_t        word0,
  output out_word_t        word1
);

  localparam int PROD_W = MAG_W + RECIP_W;

  // weighted sums, chroma split into magnitude and sign
  logic [MAG_W-1:0] y_sum, cb_pos, cb_neg, cr_pos, cr_neg;
  logic [MAG_W-1:0] s4_y_r, s4_cb_r, s4_cr_r;
  logic             s4_cb_sgn_r, s4_cr_sgn_r, s4_valid_r, s4_odd_r, s4_last_r;

  logic [PROD_W-1:0] prod_y, prod_cb, prod_cr;
  logic [QW-1:0]     s5_y_r, s5_cb_r, s5_cr_r;
  logic              s5_cb_sgn_r, s5_cr_sgn_r, s5_valid_r, s5_odd_r, s5_last_r;

  logic [PIX_W-1:0] y_val, cb_val, cr_val;
  logic [PIX_W-1:0] held_y_r, held_cb_r, held_cr_r;
  logic [PIX_W:0]   cb_sum, cr_sum;

  assign y_sum  = MAG_W'(red) * K_Y_R + MAG_W'(grn) * K_Y_G + MAG_W'(blu) * K_Y_B;
  assign cb_pos = MAG_W'(blu) * K_CB_B;
  assign cb_neg = MAG_W'(red) * K_CB_R + MAG_W'(grn) * K_CB_G;
  assign cr_pos = MAG_W'(red) * K_CR_R;
  assign cr_neg = MAG_W'(grn) * K_CR_G + MAG_W'(blu) * K_CR_B;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_y_r      <= y_sum;
      s4_cb_sgn_r <= cb_neg > cb_pos;
      s4_cb_r     <= (cb_neg > cb_pos) ? cb_neg - cb_pos : cb_pos - cb_neg;
      s4_cr_sgn_r <= cr_neg > cr_pos;
      s4_cr_r     <= (cr_neg > cr_pos) ? cr_neg - cr_pos : cr_pos - cr_neg;
      s4_odd_r    <= s3_ctrl.odd_col;
      s4_last_r   <= s3_ctrl.last;
    end
  end

  // divide magnitudes by 1000 through the reciprocal; truncates toward zero
  assign prod_y  = PROD_W'(s4_y_r) * PROD_W'(RECIP);
  assign prod_cb = PROD_W'(s4_cb_r) * PROD_W'(RECIP);
  assign prod_cr = PROD_W'(s4_cr_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_y_r      <= prod_y[REC_SH +: QW];
      s5_cb_r     <= prod_cb[REC_SH +: QW];
      s5_cr_r     <= prod_cr[REC_SH +: QW];
      s5_cb_sgn_r <= s4_cb_sgn_r;
      s5_cr_sgn_r <= s4_cr_sgn_r;
      s5_odd_r    <= s4_odd_r;
      s5_last_r   <= s4_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid;
      s5_valid_r <= s4_valid_r;
    end
  end

  // offsets wrap modulo 256
  assign y_val  = Y_OFS + s5_y_r;
  assign cb_val = C_OFS + (s5_cb_sgn_r ? (~s5_cb_r + PIX_W'(1)) : s5_cb_r);
  assign cr_val = C_OFS + (s5_cr_sgn_r ? (~s5_cr_r + PIX_W'(1)) : s5_cr_r);

  // hold the even pixel until its odd partner arrives
  always_ff @(posedge clk) begin
    if (adv && s5_valid_r && !s5_odd_r) begin
      held_y_r  <= y_val;
      held_cb_r <= cb_val;
      held_cr_r <= cr_val;
    end
  end

  assign cb_sum = (PIX_W+1)'(cb_val) + (PIX_W+1)'(held_cb_r);
  assign cr_sum = (PIX_W+1)'(cr_val) + (PIX_W+1)'(held_cr_r);

  assign push = adv && s5_valid_r && s5_odd_r;

  always_comb begin
    word0.ycc        = {cb_sum[PIX_W:1], held_y_r};
    word0.pair_last  = 1'b0;
    word0.frame_last = 1'b0;
    word1.ycc        = {cr_sum[PIX_W:1], y_val};
    word1.pair_last  = 1'b1;
    word1.frame_last = s5_last_r;
  end

endmodule

>>> design/bdm_out_fifo.sv
// ----------------------------------------------------------------------------
// bdm_out_fifo
// Small result queue: two words in per pair, one word out per transfer.
// ----------------------------------------------------------------------------
module bdm_out_fifo import bdm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t word0,
  input  out_word_t word1,
  input  logic      out_stall,
  output logic      room,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  out_word_t        q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);
  assign cnt_nxt   = cnt_r + (push ? CNT_W'(2) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(2);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r]  <= word0;
      q_r[wr_ptr_p1] <= word1;
    end
  end

  assign room      = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_word  = q_r[rd_ptr_r];

endmodule

>>> design/bayer_demosaic_to_ycbcr422_core.sv
// Ordering: a pixel's pair leaves with the item that arrives line_width+1 items later;
//   its words pass the s1, window, interpolation, s4 and s5 registers; Cb leaves before Cr.
// Throughput: one item per cycle while the queue has room for a pair, set by the line store
//   (one read, one write-back per column per cycle) and the queue (one word out per cycle).
// Reset: synchronous, active-low; clears counters, pipeline valids and the queue and
//   loads line_width=1920, frame_height=1080. The line memory is not cleared.
// ----------------------------------------------------------------------------
// bayer_demosaic_to_ycbcr422_core
// RGGB Bayer raster stream to BT.709 YCbCr 4:2:2 with bilinear demosaic.
// ----------------------------------------------------------------------------
module bayer_demosaic_to_ycbcr422_core import bdm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // pixel input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [WORD_W-1:0]    in_pixel_word,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_ycc_word,
  output logic                 out_pair_last,
  output logic                 out_frame_last,
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;

  // Clamp the programmed width to 4..MAX_WIDTH and force it even.
  function automatic logic [CNT_W-1:0] eff_width(input logic [CFG_W-1:0] v);
    logic [CFG_W:0] c;
    c = {1'b0, v};
    if (v < WIDTH_MIN) c = {1'b0, WIDTH_MIN};
    if (c > (CFG_W+1)'(MAX_WIDTH)) c = (CFG_W+1)'(MAX_WIDTH);
    c[0] = 1'b0;
    return CNT_W'(c);
  endfunction

  function automatic logic [ROW_W-1:0] eff_height(input logic [CFG_W-1:0] v);
    return (v < HEIGHT_MIN) ? HEIGHT_MIN : v;
  endfunction

  logic [CNT_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;

  logic             adv, accept, restart;
  logic [COL_W-1:0] rd_addr, s1_addr;
  logic             s1_valid, s2_valid, s3_valid, push;
  logic [PIX_W-1:0] s1_px, red, grn, blu;
  pix_ctrl_t        s1_ctrl, s2_ctrl, s3_ctrl;
  win_t             win;
  out_word_t        word0, word1, out_word;

  // Registers are always writable; a write restarts the frame counters.
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= eff_width(WIDTH_RST);
      height_r <= eff_height(HEIGHT_RST);
    end else if (restart) begin
      case (cfg_index)
        REG_LINE_WIDTH:   width_r  <= eff_width(cfg_data);
        REG_FRAME_HEIGHT: height_r <= eff_height(cfg_data);
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it advances whenever the output
  // queue can absorb a full pair. Hold every stage otherwise.
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Front end: raster counters, border flags, line store read issue.
  bdm_seq #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .accept     (accept),
    .restart    (restart),
    .width      (width_r),
    .height     (height_r),
    .command    (in_command),
    .pixel_word (in_pixel_word),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .s1_px      (s1_px),
    .s1_addr    (s1_addr),
    .s1_ctrl    (s1_ctrl)
  );

  // Line memory read-modify-write and window shift. Entries never written
  // in the current frame only ever land on masked border taps, so the
  // memory needs no clearing pass.
  bdm_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1_px    (s1_px),
    .s1_addr  (s1_addr),
    .s1_ctrl  (s1_ctrl),
    .s2_valid (s2_valid),
    .s2_ctrl  (s2_ctrl),
    .win      (win)
  );

  // Demosaic the window center.
  bdm_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s2_valid (s2_valid),
    .s2_ctrl  (s2_ctrl),
    .win      (win),
    .s3_valid (s3_valid),
    .s3_ctrl  (s3_ctrl),
    .red      (red),
    .grn      (grn),
    .blu      (blu)
  );

  // Color conversion; even pixels are held, odd pixels emit the pair.
  bdm_csc u_csc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s3_valid (s3_valid),
    .s3_ctrl  (s3_ctrl),
    .red      (red),
    .grn      (grn),
    .blu      (blu),
    .push     (push),
    .word0    (word0),
    .word1    (word1)
  );

  // Output queue decouples the pair burst from the one-word-per-transfer side.
  bdm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .word0     (word0),
    .word1     (word1),
    .out_stall (out_stall),
    .room      (adv),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_ycc_word   = out_word.ycc;
  assign out_pair_last  = out_word.pair_last;
  assign out_frame_last = out_word.frame_last;

endmodule

>>> design/bdm_checker.sv
// ----------------------------------------------------------------------------
// bdm_checker
// Port-level checks on the result channel of the demosaic core.
// ----------------------------------------------------------------------------
module bdm_checker import bdm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [WORD_W-1:0] out_ycc_word,
  input logic              out_pair_last,
  input logic              out_frame_last
);

  logic expect_cr_r;

  // track which word of a pair the next transfer must be
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_cr_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      expect_cr_r <= !expect_cr_r;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ycc_word)
      && $stable(out_pair_last) && $stable(out_frame_last))
    else $error("result changed while stalled");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> out_pair_last == expect_cr_r)
    else $error("Cb/Cr words out of order");

  a_frame_on_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_pair_last)
    else $error("frame end flagged on a Cb word");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bayer_demosaic_to_ycbcr422_core bdm_checker u_bdm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ycc_word   (out_ycc_word),
  .out_pair_last  (out_pair_last),
  .out_frame_last (out_frame_last)
);
